[sv/lpht_pkg.sv]
package lpht_pkg;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int MOD_STEPS = 6;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP        = 2'd0,
        OP_INSERT        = 2'd1,
        OP_LOOKUP_INSERT = 2'd2,
        OP_CLEAR         = 2'd3
    } lpht_op_t;

    typedef struct packed {
        lpht_op_t           opcode;
        logic [KEY_W-1:0]   lookup_key;
        logic [VAL_W-1:0]   new_value;
    } lpht_req_t;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   old_value;
        logic               status;
    } lpht_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic clr_start;
        logic clr_step;
        logic load_home;
        logic rd;
        logic advance;
        logic finish;
    } lpht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic slot_empty;
        logic key_hit;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } lpht_stat_t;

endpackage

[sv/lpht_chan_if.sv]
interface lpht_chan_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);

endinterface

[sv/lpht_ctrl.sv]
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  lpht_op_t   req_opcode,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd,
    output logic       ready
);

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (ready_reg && req_valid)
                begin
                    cmd.take = 1'b1;
                    if (req_opcode == OP_CLEAR)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                if (stat.mod_done)
                begin
                    cmd.load_home = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_empty || stat.key_hit || stat.probe_last)
                begin
                    // hold the read word until the result slot frees up
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign ready = ready_reg;

`ifndef ASSERT_OFF
    a_take_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> !ready_reg)
        else $error("ready still high after a word was taken");
`endif

endmodule

[sv/lpht_dp.sv]
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lpht_req_t          req_word,
    input  lpht_cmd_t          cmd,
    output lpht_stat_t         stat,
    lpht_chan_if.source        rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam bit POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    lpht_op_t           op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_wrap;
    logic [IDX_W-1:0]   home;
    logic               mod_done;

    // key memory carries the slot valid bit on top
    logic [KEY_W:0]     kmem [TABLE_SIZE];
    logic [VAL_W-1:0]   vmem [TABLE_SIZE];
    logic [KEY_W:0]     krd_reg;
    logic [VAL_W-1:0]   vrd_reg;
    logic               kmem_we, vmem_we;
    logic [KEY_W:0]     kmem_wdata;

    logic               is_ins;
    logic               slot_empty, key_hit;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [VAL_W-1:0]   out_old_reg;
    logic               out_status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= req_word.opcode;
            key_reg <= req_word.lookup_key;
            val_reg <= req_word.new_value;
        end
    end

    // home slot: key mod TABLE_SIZE
    generate
        if (POW2)
        begin : g_mod_mask
            assign home     = key_reg[IDX_W-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_mod_fold
            // fold the upper half down four times using 2^32 mod TABLE_SIZE,
            // leaving a 32-bit value with the same remainder; the reciprocal
            // quotient is at most one short, so one compare/subtract finishes
            localparam logic [IDX_W-1:0] FOLD_C = IDX_W'((64'd1 << 32) % TABLE_SIZE);
            localparam logic [31:0]      RCP_C  = 32'((64'd1 << 32) / TABLE_SIZE);
            localparam logic [IDX_W:0]   SIZE_C = (IDX_W+1)'(TABLE_SIZE);
            localparam logic [MOD_CNT_W-1:0] STEP_RCP = MOD_CNT_W'(2);
            localparam logic [MOD_CNT_W-1:0] STEP_SUB = MOD_CNT_W'(1);

            logic [KEY_W-1:0]     acc_reg;
            logic [31:0]          quo_reg;
            logic [IDX_W:0]       rem_reg;
            logic [MOD_CNT_W-1:0] mcnt_reg;
            logic [31+IDX_W:0]    fold_prod;
            logic [63:0]          rcp_prod;
            logic [32+IDX_W:0]    quo_prod;

            assign fold_prod = acc_reg[KEY_W-1:32] * FOLD_C;
            assign rcp_prod  = acc_reg[31:0] * RCP_C;
            assign quo_prod  = quo_reg * SIZE_C;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mcnt_reg <= '0;
                end
                else if (cmd.take)
                begin
                    mcnt_reg <= MOD_CNT_W'(MOD_STEPS);
                end
                else if (mcnt_reg != '0)
                begin
                    mcnt_reg <= mcnt_reg - 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.take)
                begin
                    acc_reg <= req_word.lookup_key;
                end
                else if (mcnt_reg > STEP_RCP)
                begin
                    acc_reg <= KEY_W'(fold_prod) + {32'd0, acc_reg[31:0]};
                end
                if (mcnt_reg == STEP_RCP)
                begin
                    quo_reg <= rcp_prod[63:32];
                end
                if (mcnt_reg == STEP_SUB)
                begin
                    rem_reg <= acc_reg[IDX_W:0] - quo_prod[IDX_W:0];
                end
            end

            assign home     = (rem_reg >= SIZE_C) ? IDX_W'(rem_reg - SIZE_C)
                                                  : rem_reg[IDX_W-1:0];
            assign mod_done = (mcnt_reg == '0);
        end
    endgenerate

    assign idx_wrap = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (cmd.load_home)
        begin
            idx_next = home;
            cnt_next = '0;
        end
        if (cmd.clr_start)
        begin
            idx_next = '0;
        end
        if (cmd.advance)
        begin
            idx_next = idx_wrap;
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.clr_step)
        begin
            idx_next = idx_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    assign is_ins     = (op_reg == OP_INSERT) || (op_reg == OP_LOOKUP_INSERT);
    assign slot_empty = !krd_reg[KEY_W];
    assign key_hit    = krd_reg[KEY_W] && (krd_reg[KEY_W-1:0] == key_reg);

    assign vmem_we    = cmd.finish && is_ins && (key_hit || slot_empty);
    assign kmem_we    = cmd.clr_step || vmem_we;
    assign kmem_wdata = {!cmd.clr_step, key_reg};

    always_ff @(posedge clk)
    begin
        if (kmem_we)
        begin
            kmem[idx_reg] <= kmem_wdata;
        end
        if (vmem_we)
        begin
            vmem[idx_reg] <= val_reg;
        end
        if (cmd.rd)
        begin
            krd_reg <= kmem[idx_reg];
            vrd_reg <= vmem[idx_reg];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (op_reg == OP_CLEAR)
            begin
                out_found_reg  <= 1'b0;
                out_old_reg    <= '0;
                out_status_reg <= 1'b0;
            end
            else
            begin
                out_found_reg  <= key_hit;
                out_old_reg    <= key_hit ? vrd_reg : '0;
                out_status_reg <= is_ins && !key_hit && !slot_empty;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.word.found     = out_found_reg;
    assign rsp.word.old_value = out_old_reg;
    assign rsp.word.status    = out_status_reg;

    assign stat.mod_done   = mod_done;
    assign stat.slot_empty = slot_empty;
    assign stat.key_hit    = key_hit;
    assign stat.probe_last = (cnt_reg == LAST_IDX);
    assign stat.clr_last   = (idx_reg == LAST_IDX);
    assign stat.out_free   = !out_valid_reg || rsp.ready;

`ifndef ASSERT_OFF
    a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || rsp.ready))
        else $error("result overwrites a word not yet taken");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> !out_found_reg)
        else $error("full status on a key that was found");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> (cnt_reg != LAST_IDX))
        else $error("probe ran past the table size");
`endif

endmodule

[sv/linear_probe_hash_table_unit.sv]
// Channel  Dir  Word fields                           Handshake
// req      in   opcode, lookup_key, new_value         valid/ready
// rsp      out  found, old_value, status              valid/ready
//
// One operation at a time. Home slot: key mask for a power-of-two table,
// else four 32-bit folds and a reciprocal multiply. Each probe is a
// registered memory read, then a compare. Clear sweeps the valid bits, one
// slot a cycle. After reset the same sweep runs with req.ready low.
// A new word is taken while the previous result waits in the output register.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    lpht_chan_if.sink    req,
    lpht_chan_if.source  rsp
);

    lpht_cmd_t  cmd;
    lpht_stat_t stat;
    logic       ctrl_ready;

    assign req.ready = ctrl_ready;

    lpht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.word.opcode),
        .stat       (stat),
        .cmd        (cmd),
        .ready      (ctrl_ready)
    );

    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_word   (req.word),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lpht_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int RANDOM_OPS = 830;
    localparam int POOL_N     = 12;

    // Shadow copy of the table; predicts one response per accepted request word.
    class hash_scoreboard;
        logic [KEY_W-1:0] key_mem  [SLOTS];
        logic [VAL_W-1:0] val_mem  [SLOTS];
        bit               occupied [SLOTS];
        lpht_rsp_t        expected_q [$];
        int               mismatches;
        int               checked;

        function new();
            mismatches = 0;
            checked    = 0;
            foreach (occupied[i]) occupied[i] = 1'b0;
        endfunction

        function void note_request(lpht_req_t w);
            lpht_rsp_t   r;
            int unsigned idx;
            int          free_idx;
            bit          hit;
            r        = '0;
            hit      = 1'b0;
            free_idx = -1;
            if (w.opcode == OP_CLEAR) begin
                foreach (occupied[i]) occupied[i] = 1'b0;
            end else begin
                idx = 32'(w.lookup_key % SLOTS);
                for (int n = 0; n < SLOTS; n++) begin
                    if (!occupied[idx]) begin
                        free_idx = int'(idx);
                        break;
                    end
                    if (key_mem[idx] == w.lookup_key) begin
                        hit = 1'b1;
                        break;
                    end
                    idx = (idx + 1) % SLOTS;
                end
                if (hit) begin
                    r.found     = 1'b1;
                    r.old_value = val_mem[idx];
                end
                if (w.opcode != OP_LOOKUP) begin
                    if (hit) begin
                        val_mem[idx] = w.new_value;
                    end else if (free_idx >= 0) begin
                        occupied[free_idx] = 1'b1;
                        key_mem[free_idx]  = w.lookup_key;
                        val_mem[free_idx]  = w.new_value;
                    end else begin
                        r.status = 1'b1;   // no free slot, insert dropped
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(lpht_rsp_t got);
            lpht_rsp_t want;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d with nothing pending: found=%0b old=%h st=%0b",
                             checked, got.found, got.old_value, got.status);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found || got.old_value !== want.old_value ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: response %0d expected found=%0b old=%h st=%0b",
                             checked, want.found, want.old_value, want.status);
                    $display("       got                 found=%0b old=%h st=%0b",
                             got.found, got.old_value, got.status);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   send_steady;

    hash_scoreboard sb = new();

    lpht_chan_if #(.word_t(lpht_req_t)) req_if ();
    lpht_chan_if #(.word_t(lpht_rsp_t)) rsp_if ();

    linear_probe_hash_table_unit #(
        .TABLE_SIZE (SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, a few long ones; none at all in steady stretches
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random upper bits, home slot within spread of base
    function automatic logic [63:0] cluster_key(int unsigned base, int unsigned spread);
        logic [63:0] k;
        k = {$urandom, $urandom};
        return k - (k % SLOTS) + ((base + $urandom_range(0, spread)) % SLOTS);
    endfunction

    task automatic send_word(lpht_op_t op, logic [63:0] key, logic [63:0] value);
        lpht_req_t w;
        int        gap;
        w.opcode     = op;
        w.lookup_key = key;
        w.new_value  = value;
        req_if.valid <= 1'b1;
        req_if.word  <= w;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(w);
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = pick_gap(send_steady);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        send_word(OP_LOOKUP, 64'd0, 64'd0);                       // empty table
        send_word(OP_INSERT, 64'd0, '1);
        send_word(OP_INSERT, '1, 64'd0);                          // home is last slot
        send_word(OP_LOOKUP, '1, '1);
        send_word(OP_LOOKUP_INSERT, 64'd0, 64'h0123_4567_89ab_cdef);
        send_word(OP_LOOKUP, 64'(SLOTS), 64'd5);                  // same home, absent
        send_word(OP_INSERT, 64'(SLOTS), 64'ha5a5_a5a5_5a5a_5a5a);
        send_word(OP_LOOKUP_INSERT, 64'(2 * SLOTS - 1), '1);      // wraps past the end
        send_word(OP_LOOKUP, 64'(2 * SLOTS - 1), 64'd0);
        send_word(OP_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_word(OP_LOOKUP, 64'h8000_0000_0000_0000 + 64'(SLOTS), 64'd0);
        send_word(OP_LOOKUP_INSERT, 64'd0, 64'hffff_0000_ffff_0000);
        send_word(OP_CLEAR, '1, '1);
        send_word(OP_LOOKUP, 64'd0, 64'd0);
        send_word(OP_LOOKUP_INSERT, '1, 64'h5a5a_5a5a_a5a5_a5a5);
        send_word(OP_LOOKUP, '1, 64'd0);
        send_word(OP_CLEAR, 64'd0, 64'd0);
    endtask

    // keys drawn from a small pool clustered around a few homes, so probe
    // chains form and most lookups and updates hit
    task automatic run_random();
        logic [63:0] pool [POOL_N];
        int unsigned base;
        int          r;
        lpht_op_t    op;
        logic [63:0] key;
        base = 0;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 100 == 0)
            begin
                base = ($urandom_range(0, 3) == 0) ? SLOTS - 5 : $urandom_range(0, SLOTS - 1);
                foreach (pool[k]) pool[k] = cluster_key(base, 7);
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                op = OP_CLEAR;
            else if (r < 36)
                op = OP_LOOKUP;
            else if (r < 68)
                op = OP_INSERT;
            else
                op = OP_LOOKUP_INSERT;
            r = $urandom_range(0, 99);
            if (r < 75)
                key = pool[$urandom_range(0, POOL_N - 1)];
            else if (r < 90)
                key = cluster_key(base, 7);
            else
                key = {$urandom, $urandom};
            send_word(op, key, {$urandom, $urandom});
        end
    endtask

    initial
    begin : stimulus
        int wait_cycles;
        send_steady = 1'b0;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.word  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        req_if.valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        // wait out a full-table probe; catch any stray word
        repeat (2200) @(posedge clk);
        if (sb.pending() == 0 && sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // response side: random stalls, plus one long hold-off so the request
    // side backs up
    initial
    begin : drain
        int stall_left;
        int received;
        bit steady;
        stall_left = 0;
        received   = 0;
        steady     = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                sb.check_result(rsp_if.word);
                received++;
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                stall_left = (received == 150) ? 400 : pick_gap(steady);
            end
            if (rst_n && stall_left == 0)
                rsp_if.ready <= 1'b1;
            else
            begin
                rsp_if.ready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/lpht_pkg.sv
sv/lpht_chan_if.sv
sv/lpht_ctrl.sv
sv/lpht_dp.sv
sv/linear_probe_hash_table_unit.sv
tb/testbench.sv
